/* rtl/afr_pkg.sv */
`timescale 1ns / 1ps

package afr_pkg;

	// Fixed-point formats
	localparam int FRACTION_BITS     = 16;
	localparam int LOG_TABLE_ENTRIES = 256;
	localparam int IDX_W             = $clog2(LOG_TABLE_ENTRIES);

	localparam int SAMPLE_W = 32;
	localparam int FLOOR_W  = 17;
	localparam int ABS_W    = 21;
	localparam int ABS_HIGH = 524288;

	// Positive sample magnitude and its leading-one position
	localparam int X_W = SAMPLE_W - 1;
	localparam int E_W = $clog2(X_W);

	// log2 values are Q.30
	localparam int LOG_FRAC = 30;
	localparam int T_W      = LOG_FRAC + 1;

	// Divide by 100 as a multiply by a rounded-up reciprocal; exact for 32-bit dividends
	localparam int                DIV_W         = 32;
	localparam int                DIV100_SHIFT  = 38;
	localparam logic [DIV_W-1:0]  DIV100_MULT   = 32'd2748779070;
	localparam logic [DIV_W-1:0]  PCT_HALF      = 32'd50;
	localparam int                Q_W           = 2 * DIV_W - DIV100_SHIFT;

	// Scaling by log10(2), Q.28
	localparam int               C_W         = 27;
	localparam logic [C_W-1:0]   LOG10_2_Q28 = 27'd80807124;
	localparam int               EXP_D_W     = E_W + 2;
	localparam int               S_W         = EXP_D_W + LOG_FRAC + 1;
	localparam int               MAG_W       = LOG_FRAC + 5;
	localparam int               RSUM_W      = MAG_W + C_W + 1;
	localparam int               RSHIFT      = 58 - FRACTION_BITS;
	localparam logic [RSUM_W-1:0] ROUND_BIAS = RSUM_W'(1) << (57 - FRACTION_BITS);

	// Configuration register indexes
	localparam int                CFG_IDX_W        = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERCENT_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_VALUE  = 1'b1;

	// Pipeline depth and per-stage load enables
	localparam int STAGES = 9;
	typedef logic [STAGES-1:0] stage_en_t;

	// log2(1 + i/N) table, Q.30, N+1 entries
	typedef logic [LOG_TABLE_ENTRIES:0][T_W-1:0] log_rom_t;

	function automatic logic [T_W-1:0] log2_frac_q30(logic [63:0] y_in);
		logic [63:0]    y;
		logic [T_W-1:0] r;
		y = y_in;
		r = '0;
		if (y >= (64'd1 << 31)) begin
			r = T_W'(1) << LOG_FRAC;
		end else begin
			for (int b = LOG_FRAC - 1; b >= 0; b--) begin
				y = (y * y) >> LOG_FRAC;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					r[b] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic log_rom_t build_log_rom();
		log_rom_t    rom;
		logic [63:0] y;
		for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
			y = (64'd1 << LOG_FRAC) + ((64'(i) << LOG_FRAC) / LOG_TABLE_ENTRIES);
			rom[i] = log2_frac_q30(y);
		end
		return rom;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

/* rtl/afr_if.sv */
`timescale 1ns / 1ps

interface afr_in_if;
	import afr_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_in;

	modport source(output valid, output sample, output last_in, input ready);
	modport sink(input valid, input sample, input last_in, output ready);
endinterface

interface afr_out_if;
	import afr_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [ABS_W-1:0] absorbance;
	logic                    last_out;

	modport source(output valid, output absorbance, output last_out, input ready);
	modport sink(input valid, input absorbance, input last_out, output ready);
endinterface

/* rtl/absorbance_from_transmittance_unit.sv */
`timescale 1ns / 1ps

// Absorbance unit: each item carries a signed Q16.16 transmittance sample and
// returns -log10 of it as a signed Q.16 absorbance, with the last flag copied
// through. In percent mode the sample is divided by 100 (rounded half up)
// first; the value is then raised to the floor register, so zero and negative
// samples give a finite result. The logarithm comes from a leading-one
// normalize, a 257-entry log2 table and linear interpolation. The unit is a
// nine-stage pipeline: it takes one item per clock while the result side is
// ready. Empty stages keep filling while the result side stalls. Write the
// two configuration registers only while no items are in flight.
module absorbance_from_transmittance_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [afr_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [afr_pkg::FLOOR_W-1:0]          cfg_data,
	afr_in_if.sink                               transmittance,
	afr_out_if.source                            result
);
	import afr_pkg::*;

	logic               percent_mode_q;
	logic [FLOOR_W-1:0] floor_value_q;
	stage_en_t          load;
	stage_en_t          valid_q;
	stage_en_t          last_s;
	logic [X_W-1:0]     x_prep;
	logic [T_W-1:0]     lfrac;
	logic [E_W-1:0]     expo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			percent_mode_q <= 1'b0;
			floor_value_q  <= FLOOR_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PERCENT_MODE: percent_mode_q <= cfg_data[0];
				CFG_FLOOR_VALUE:  floor_value_q  <= cfg_data;
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		load[STAGES-1] = ~valid_q[STAGES-1] | result.ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			load[k] = ~valid_q[k] | load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= transmittance.valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			last_s[0] <= transmittance.last_in;
		end
		for (int k = 1; k < STAGES; k++) begin
			if (load[k]) begin
				last_s[k] <= last_s[k-1];
			end
		end
	end

	afr_prep u_prep (
		.clk          (clk),
		.load         (load),
		.sample       (transmittance.sample),
		.percent_mode (percent_mode_q),
		.floor_value  (floor_value_q),
		.x_out        (x_prep)
	);

	afr_log2 u_log2 (
		.clk   (clk),
		.load  (load),
		.x_in  (x_prep),
		.lfrac (lfrac),
		.expo  (expo)
	);

	afr_scale u_scale (
		.clk        (clk),
		.load       (load),
		.lfrac      (lfrac),
		.expo       (expo),
		.absorbance (result.absorbance)
	);

	assign transmittance.ready = load[0];
	assign result.valid        = valid_q[STAGES-1];
	assign result.last_out     = last_s[STAGES-1];

	// A ready result side never holds back the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> transmittance.ready)
		else $error("input stalled while the result side is ready");

	// With every stage full and the output stalled, nothing more is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q == '1 && !result.ready) |-> !transmittance.ready)
		else $error("input taken into a full, stalled pipeline");

	// An accepted item occupies the first stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(transmittance.valid && transmittance.ready) |=> valid_q[0])
		else $error("accepted item lost at pipeline entry");

	// Saturation keeps every result within plus or minus ABS_HIGH.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.absorbance <= ABS_W'(ABS_HIGH)
			&& result.absorbance >= -$signed(ABS_W'(ABS_HIGH))))
		else $error("absorbance outside its range");

endmodule

/* rtl/afr_prep.sv */
`timescale 1ns / 1ps

module afr_prep (
	input  logic                                 clk,
	input  afr_pkg::stage_en_t                   load,
	input  logic signed [afr_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 percent_mode,
	input  logic [afr_pkg::FLOOR_W-1:0]          floor_value,
	output logic [afr_pkg::X_W-1:0]              x_out
);
	import afr_pkg::*;

	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [X_W-1:0]             xpos;
	logic [DIV_W-1:0]           rounded;
	logic [2*DIV_W-1:0]         prod;
	logic [2*DIV_W-1:0]         prod_s2;
	logic [X_W-1:0]             xpos_s2;
	logic [X_W-1:0]             xsel;
	logic [FLOOR_W-1:0]         floor_eff;
	logic [X_W-1:0]             floor_ext;
	logic [X_W-1:0]             x_s3;

	// Zero and negative samples contribute nothing; the floor takes over below.
	always_comb begin
		xpos    = (sample_s1 > 0) ? sample_s1[X_W-1:0] : '0;
		rounded = {1'b0, xpos} + PCT_HALF;
		prod    = rounded * DIV100_MULT;
	end

	always_comb begin
		xsel      = percent_mode ? X_W'(prod_s2[DIV100_SHIFT +: Q_W]) : xpos_s2;
		floor_eff = (floor_value == '0) ? FLOOR_W'(1) : floor_value;
		floor_ext = X_W'(floor_eff);
	end

	always_ff @(posedge clk) begin
		if (load[0]) begin
			sample_s1 <= sample;
		end
		if (load[1]) begin
			prod_s2 <= prod;
			xpos_s2 <= xpos;
		end
		if (load[2]) begin
			x_s3 <= (xsel < floor_ext) ? floor_ext : xsel;
		end
	end

	assign x_out = x_s3;

endmodule

/* rtl/afr_log2.sv */
`timescale 1ns / 1ps

module afr_log2 (
	input  logic                      clk,
	input  afr_pkg::stage_en_t        load,
	input  logic [afr_pkg::X_W-1:0]   x_in,
	output logic [afr_pkg::T_W-1:0]   lfrac,
	output logic [afr_pkg::E_W-1:0]   expo
);
	import afr_pkg::*;

	logic [E_W-1:0]   lead;
	logic [X_W-1:0]   x_s4;
	logic [E_W-1:0]   e_s4;
	logic [X_W-1:0]   xn;
	logic [IDX_W-1:0] idx;
	logic [X_W-1:0]   rem;
	logic [IDX_W-1:0] idx_s5;
	logic [X_W-1:0]   rem_s5;
	logic [E_W-1:0]   e_s5;
	logic [IDX_W:0]   idx_hi;
	logic [T_W-1:0]   lo;
	logic [T_W-1:0]   hi;
	logic [T_W-1:0]   lo_s6;
	logic [T_W-1:0]   diff_s6;
	logic [X_W-1:0]   rem_s6;
	logic [E_W-1:0]   e_s6;
	logic [T_W+X_W-1:0] prod;
	logic [T_W-1:0]   l_s7;
	logic [E_W-1:0]   e_s7;

	// Leading-one position; the input is never zero after the floor.
	always_comb begin
		lead = '0;
		for (int i = 0; i < X_W; i++) begin
			if (x_in[i]) begin
				lead = E_W'(i);
			end
		end
	end

	// Normalize so the leading one sits at the top; the bits below it are the
	// mantissa fraction, split into a table index and an interpolation weight.
	always_comb begin
		xn  = x_s4 << (E_W'(X_W - 1) - e_s4);
		idx = xn[X_W-2 -: IDX_W];
		rem = {xn[X_W-2-IDX_W:0], {(IDX_W + 1){1'b0}}};
	end

	always_comb begin
		idx_hi = {1'b0, idx_s5} + 1'b1;
		lo     = LOG_ROM[{1'b0, idx_s5}];
		hi     = LOG_ROM[idx_hi];
	end

	assign prod = diff_s6 * rem_s6;

	always_ff @(posedge clk) begin
		if (load[3]) begin
			x_s4 <= x_in;
			e_s4 <= lead;
		end
		if (load[4]) begin
			idx_s5 <= idx;
			rem_s5 <= rem;
			e_s5   <= e_s4;
		end
		if (load[5]) begin
			lo_s6   <= lo;
			diff_s6 <= hi - lo;
			rem_s6  <= rem_s5;
			e_s6    <= e_s5;
		end
		if (load[6]) begin
			l_s7 <= lo_s6 + prod[X_W +: T_W];
			e_s7 <= e_s6;
		end
	end

	assign lfrac = l_s7;
	assign expo  = e_s7;

endmodule

/* rtl/afr_scale.sv */
`timescale 1ns / 1ps

module afr_scale (
	input  logic                              clk,
	input  afr_pkg::stage_en_t                load,
	input  logic [afr_pkg::T_W-1:0]           lfrac,
	input  logic [afr_pkg::E_W-1:0]           expo,
	output logic signed [afr_pkg::ABS_W-1:0]  absorbance
);
	import afr_pkg::*;

	logic signed [EXP_D_W-1:0] exp_d;
	logic signed [S_W-1:0]     s;
	logic signed [S_W-1:0]     s_abs;
	logic [MAG_W-1:0]          mag_s8;
	logic                      neg_s8;
	logic [RSUM_W-1:0]         rsum;
	logic [RSUM_W-1:0]         m_full;
	logic [ABS_W-1:0]          m_sat;
	logic signed [ABS_W-1:0]   abs_s9;

	// log2 in Q.30: integer part from the exponent, fraction from the table.
	always_comb begin
		exp_d = $signed({2'b00, expo}) - EXP_D_W'(FRACTION_BITS);
		s     = (S_W'(exp_d) <<< LOG_FRAC) + $signed(S_W'(lfrac));
		s_abs = s[S_W-1] ? -s : s;
	end

	// Round half away from zero on the magnitude, then saturate.
	always_comb begin
		rsum   = RSUM_W'(mag_s8) * RSUM_W'(LOG10_2_Q28) + ROUND_BIAS;
		m_full = rsum >> RSHIFT;
		m_sat  = (m_full > RSUM_W'(ABS_HIGH)) ? ABS_W'(ABS_HIGH) : m_full[ABS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (load[7]) begin
			mag_s8 <= s_abs[MAG_W-1:0];
			neg_s8 <= ~s[S_W-1];
		end
		if (load[8]) begin
			abs_s9 <= neg_s8 ? -$signed(m_sat) : $signed(m_sat);
		end
	end

	assign absorbance = abs_s9;

endmodule
